/* hw/rtl/swkr_pkg.sv */
// ----------------------------------------------------------------------------
// swkr_pkg: shared types and constants
// Field widths of the request and response beats, operation codes and
// status codes of the keyed-removal stack.
// ----------------------------------------------------------------------------
package swkr_pkg;

   localparam int unsigned FUNC_BITS   = 1;
   localparam int unsigned CAR_ID_BITS = 16;
   localparam int unsigned STATUS_BITS = 2;
   localparam int unsigned OCC_BITS    = 4;
   localparam int unsigned POS_BITS    = 3;

   typedef enum logic [FUNC_BITS-1:0] {
      FUNC_PUSH   = 1'b0,
      FUNC_REMOVE = 1'b1
   } func_type;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_NOT_FOUND = 2'd2
   } status_type;

endpackage

/* hw/rtl/swkr_if.sv */
// ----------------------------------------------------------------------------
// swkr_if: request and response channels
// Valid/ready channels carrying one request beat and one response beat.
// ----------------------------------------------------------------------------
interface swkr_req_if import swkr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [FUNC_BITS-1:0]   func;
   logic [CAR_ID_BITS-1:0] car_id;

   modport source (output valid, output func, output car_id, input ready);
   modport sink   (input valid, input func, input car_id, output ready);
endinterface

interface swkr_rsp_if import swkr_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [STATUS_BITS-1:0] status;
   logic [OCC_BITS-1:0]    occupancy;
   logic [POS_BITS-1:0]    removed_position;

   modport source (output valid, output status, output occupancy,
                   output removed_position, input ready);
   modport sink   (input valid, input status, input occupancy,
                   input removed_position, output ready);
endinterface

/* hw/rtl/swkr_mem.sv */
// ----------------------------------------------------------------------------
// swkr_mem: slot memory
// Simple dual-port synchronous RAM, one write and one read port, with the
// read data registered.
// ----------------------------------------------------------------------------
module swkr_mem #(
   parameter int unsigned DEPTH = 8,
   parameter int unsigned WIDTH = 16,
   localparam int unsigned AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* hw/rtl/swkr_ctrl.sv */
// ----------------------------------------------------------------------------
// swkr_ctrl: stack sequencer
// Holds the fill count, walks the slot memory top-down for a remove, moves
// the entries above a hit down one slot, and owns the response register.
// ----------------------------------------------------------------------------
module swkr_ctrl import swkr_pkg::*; #(
   parameter int unsigned DEPTH    = 8,
   parameter int unsigned KEY_BITS = 16,
   localparam int unsigned AW      = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                reset,
   swkr_req_if.sink            req,
   swkr_rsp_if.source          rsp,
   output logic                mem_wr_en,
   output logic [AW-1:0]       mem_wr_addr,
   output logic [KEY_BITS-1:0] mem_wr_data,
   output logic                mem_rd_en,
   output logic [AW-1:0]       mem_rd_addr,
   input  logic [KEY_BITS-1:0] mem_rd_data
);

   localparam int unsigned CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_FINISH
   } state_type;

   state_type            state_ff, state_in;
   logic [CW-1:0]        count_ff, count_in;
   logic [KEY_BITS-1:0]  key_ff, key_in;
   logic [AW-1:0]        ptr_ff, ptr_in;
   logic [AW-1:0]        pos_ff, pos_in;
   status_type           status_ff, status_in;
   logic                 out_valid_ff, out_valid_in;
   status_type           out_status_ff, out_status_in;
   logic [OCC_BITS-1:0]  out_occ_ff, out_occ_in;
   logic [POS_BITS-1:0]  out_pos_ff, out_pos_in;
   logic [CW-1:0]        ptr_wide;
   logic [AW-1:0]        top_addr;

   assign ptr_wide = CW'(ptr_ff);
   assign top_addr = AW'(count_ff - CW'(1));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      key_in        = key_ff;
      ptr_in        = ptr_ff;
      pos_in        = pos_ff;
      status_in     = status_ff;
      out_valid_in  = out_valid_ff;
      out_status_in = out_status_ff;
      out_occ_in    = out_occ_ff;
      out_pos_in    = out_pos_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = ptr_ff;
      mem_wr_data   = mem_rd_data;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = ptr_ff;

      if (out_valid_ff && rsp.ready) begin
         out_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req.valid) begin
               key_in = KEY_BITS'(req.car_id);
               pos_in = '0;
               if (req.func == FUNC_PUSH) begin
                  state_in = ST_FINISH;
                  if (count_ff == CW'(DEPTH)) begin
                     status_in = STATUS_FULL;
                  end else begin
                     status_in   = STATUS_DONE;
                     mem_wr_en   = 1'b1;
                     mem_wr_addr = AW'(count_ff);
                     mem_wr_data = KEY_BITS'(req.car_id);
                     count_in    = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  status_in = STATUS_NOT_FOUND;
                  state_in  = ST_FINISH;
               end else begin
                  // Start the walk at the top entry.
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = top_addr;
                  ptr_in      = top_addr;
                  state_in    = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (mem_rd_data == key_ff) begin
               status_in = STATUS_DONE;
               pos_in    = ptr_ff;
               if (ptr_wide == count_ff - CW'(1)) begin
                  count_in = count_ff - CW'(1);
                  state_in = ST_FINISH;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = ptr_ff + AW'(1);
                  state_in    = ST_SHIFT;
               end
            end else if (ptr_ff == '0) begin
               status_in = STATUS_NOT_FOUND;
               pos_in    = '0;
               state_in  = ST_FINISH;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_ff - AW'(1);
               ptr_in      = ptr_ff - AW'(1);
            end
         end
         ST_SHIFT: begin
            // The data read last cycle belongs one slot lower.
            mem_wr_en   = 1'b1;
            mem_wr_addr = ptr_ff;
            mem_wr_data = mem_rd_data;
            if (ptr_wide + CW'(2) == count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = ST_FINISH;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = ptr_ff + AW'(1) + AW'(1);
               ptr_in      = ptr_ff + AW'(1);
            end
         end
         ST_FINISH: begin
            if (!out_valid_ff || rsp.ready) begin
               out_valid_in  = 1'b1;
               out_status_in = status_ff;
               out_occ_in    = OCC_BITS'(count_ff);
               out_pos_in    = POS_BITS'(pos_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      ptr_ff        <= ptr_in;
      pos_ff        <= pos_in;
      status_ff     <= status_in;
      out_status_ff <= out_status_in;
      out_occ_ff    <= out_occ_in;
      out_pos_ff    <= out_pos_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign req.ready            = (state_ff == ST_IDLE);
   assign rsp.valid            = out_valid_ff;
   assign rsp.status           = out_status_ff;
   assign rsp.occupancy        = out_occ_ff;
   assign rsp.removed_position = out_pos_ff;

endmodule

/* hw/rtl/stack_with_keyed_removal.sv */
// ----------------------------------------------------------------------------
// stack_with_keyed_removal: bounded key stack with removal by key
// Top level. Connects the request and response channels to the sequencer
// and the slot memory.
// ----------------------------------------------------------------------------
// Usage
// A request beat on req_chan carries func (push or remove) and car_id, the
// key. Only the low KEY_BITS bits of the key are stored and compared.
// Every request returns exactly one response beat on rsp_chan with status,
// the occupancy after the request, and the slot (bottom is zero) of the
// removed key.
// A push goes from idle straight to the finish state, which loads the
// response register once that register is free. A remove walks the slot
// memory from the top down, one entry per cycle, then moves every entry
// above the hit down one slot, one entry per cycle, and then also passes
// through the finish state. The single read port sets this pace.
// One request is in flight at a time; req_chan.ready is high only while
// the sequencer is idle. The response sits in an output register, so the
// sequencer goes back to idle and takes the next request while an earlier
// response still waits on a stalled receiver; it waits only when it must
// hand over another response.
// Reset empties the stack (fill count zero) and drops any pending response.
// The slot memory itself is not cleared; entries above the fill count are
// never read.
module stack_with_keyed_removal import swkr_pkg::*; #(
   parameter int unsigned DEPTH    = 8,
   parameter int unsigned KEY_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   swkr_req_if.sink   req_chan,
   swkr_rsp_if.source rsp_chan
);

   localparam int unsigned AW = $clog2(DEPTH);

   // Memory port between the sequencer and the slot RAM.
   logic                mem_wr_en;
   logic [AW-1:0]       mem_wr_addr;
   logic [KEY_BITS-1:0] mem_wr_data;
   logic                mem_rd_en;
   logic [AW-1:0]       mem_rd_addr;
   logic [KEY_BITS-1:0] mem_rd_data;

   // The sequencer keeps the fill count and the response register; it runs
   // the top-down search and the shift-down as read-modify-write passes.
   swkr_ctrl #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .rsp         (rsp_chan),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   // Slot storage. During a shift the write goes two slots below the read
   // issued in the same cycle, so the two ports never meet on one entry.
   swkr_mem #(
      .DEPTH (DEPTH),
      .WIDTH (KEY_BITS)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

endmodule

/* hw/rtl/swkr_checker.sv */
// ----------------------------------------------------------------------------
// swkr_checker: port-level checks
// Concurrent assertions on the response channel of the keyed-removal stack.
// ----------------------------------------------------------------------------
module swkr_checker import swkr_pkg::*; #(
   parameter int unsigned DEPTH = 8
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input logic [STATUS_BITS-1:0] rsp_status,
   input logic [OCC_BITS-1:0]    rsp_occupancy,
   input logic [POS_BITS-1:0]    rsp_removed_position
);

   // A stalled response beat keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
         $stable(rsp_occupancy) && $stable(rsp_removed_position))
      else $error("response beat changed while stalled");

   // Reset drops any pending response.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A refused push only happens on a full stack.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_occupancy == OCC_BITS'(DEPTH))
      else $error("full status with stack not full");

   // A response whose status is not DONE reports position zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_DONE |-> rsp_removed_position == '0)
      else $error("position reported without a removal");

   // The status code is one of the three defined values.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status == STATUS_DONE || rsp_status == STATUS_FULL ||
         rsp_status == STATUS_NOT_FOUND)
      else $error("undefined status code");

endmodule

bind stack_with_keyed_removal swkr_checker #(
   .DEPTH (DEPTH)
) u_swkr_checker (
   .clock                (clock),
   .reset                (reset),
   .rsp_valid            (rsp_chan.valid),
   .rsp_ready            (rsp_chan.ready),
   .rsp_status           (rsp_chan.status),
   .rsp_occupancy        (rsp_chan.occupancy),
   .rsp_removed_position (rsp_chan.removed_position)
);

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for the keyed-removal stack
// Pushes and removes keys through the request channel and checks every
// response beat against a behavioral stack kept here. Random idling on both
// channels and one long receiver stall are used to stress the handshakes.
// ----------------------------------------------------------------------------
module tb;
   import swkr_pkg::*;

   localparam int unsigned DEPTH       = 8;
   localparam int unsigned KEY_BITS    = 16;
   localparam int unsigned RANDOM_REQS = 500;
   localparam int unsigned CYCLE_LIMIT = 200000;
   // Slowest request plus some slack, used for the drain at the end.
   localparam int unsigned TAIL_CYCLES = 2 * DEPTH + 10;

   // One request beat as the driver sends it.
   typedef struct {
      func_type               op;
      logic [CAR_ID_BITS-1:0] car_id;
   } stack_req_type;

   // One response beat as the stack should return it.
   typedef struct {
      status_type          status;
      logic [OCC_BITS-1:0] occupancy;
      logic [POS_BITS-1:0] removed_position;
   } stack_rsp_type;

   logic clock;
   logic reset;

   swkr_req_if req_chan ();
   swkr_rsp_if rsp_chan ();

   stack_with_keyed_removal #(
      .DEPTH    (DEPTH),
      .KEY_BITS (KEY_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Requests waiting to be driven, and responses the stack still owes us.
   stack_req_type queued_reqs[$];
   stack_rsp_type owed_rsps[$];

   // Our own copy of the stack contents and its fill level.
   logic [KEY_BITS-1:0] key_stack[DEPTH];
   int                  stack_fill = 0;

   int   total_reqs     = 0;
   int   accepted_count = 0;
   int   error_count    = 0;
   int   cycle_count    = 0;
   int   stored_count   = 0;
   int   refused_count  = 0;
   int   removed_count  = 0;
   int   missed_count   = 0;
   int   hold_left      = 0;
   bit   hold_done      = 1'b0;
   logic req_taken      = 1'b0;
   logic steady_phase;

   // Both sides stop idling while this window of requests goes through.
   assign steady_phase = (accepted_count >= 100) && (accepted_count < 200);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Prints one line per mismatch and counts it.
   task automatic log_mismatch(input string what);
      $display("[%0d] mismatch: %s", cycle_count, what);
      error_count++;
   endtask

   // Applies one request to the local stack and returns the response it owes.
   // A push onto a full stack changes nothing. A remove searches from the
   // top down, so of several equal keys the topmost one goes, and the keys
   // above it slide down one slot each.
   task automatic apply_stack_req(input stack_req_type req, output stack_rsp_type rsp);
      logic [KEY_BITS-1:0] key;
      int                  hit;
      key                  = req.car_id[KEY_BITS-1:0];
      hit                  = -1;
      rsp.status           = STATUS_DONE;
      rsp.removed_position = '0;
      if (req.op == FUNC_PUSH) begin
         if (stack_fill >= DEPTH) begin
            rsp.status = STATUS_FULL;
         end else begin
            key_stack[stack_fill] = key;
            stack_fill++;
         end
      end else begin
         for (int i = stack_fill - 1; i >= 0; i--) begin
            if (hit < 0 && key_stack[i] == key) hit = i;
         end
         if (hit < 0) begin
            // An empty stack lands here as well: nothing can match.
            rsp.status = STATUS_NOT_FOUND;
         end else begin
            for (int j = hit; j + 1 < stack_fill; j++) begin
               key_stack[j] = key_stack[j + 1];
            end
            stack_fill--;
            rsp.removed_position = POS_BITS'(hit);
         end
      end
      rsp.occupancy = OCC_BITS'(stack_fill);
   endtask

   function automatic stack_req_type make_req(input func_type op,
                                              input logic [CAR_ID_BITS-1:0] car_id);
      stack_req_type req;
      req.op     = op;
      req.car_id = car_id;
      return req;
   endfunction

   // Fills the request queue: a directed opening, then random bursts.
   initial begin
      logic [CAR_ID_BITS-1:0] key_pool[6];
      logic [CAR_ID_BITS-1:0] key;
      func_type               op;
      int                     burst;
      int                     burst_len;

      // Directed part. Remove on an empty stack, fill it with extreme and
      // duplicate keys, overflow it, then take keys out from the top, the
      // middle and the bottom, plus a search for a key that is not there.
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'h0000));
      queued_reqs.push_back(make_req(FUNC_PUSH,   16'h0000));
      queued_reqs.push_back(make_req(FUNC_PUSH,   16'hFFFF));
      queued_reqs.push_back(make_req(FUNC_PUSH,   16'h1234));
      queued_reqs.push_back(make_req(FUNC_PUSH,   16'hA5A5));
      queued_reqs.push_back(make_req(FUNC_PUSH,   16'h1234));
      queued_reqs.push_back(make_req(FUNC_PUSH,   16'h5A5A));
      queued_reqs.push_back(make_req(FUNC_PUSH,   16'h0001));
      queued_reqs.push_back(make_req(FUNC_PUSH,   16'h8000));
      queued_reqs.push_back(make_req(FUNC_PUSH,   16'h7777));
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'h1234));
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'h8000));
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'h0000));
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'h9999));
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'h1234));
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'hFFFF));
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'h1234));
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'h5A5A));
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'h0001));
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'hA5A5));
      queued_reqs.push_back(make_req(FUNC_REMOVE, 16'hA5A5));

      // Random part. Keys come mostly from a small pool so that removes
      // find their targets and duplicates pile up. Alternating push and
      // remove bursts drive the stack to full and back to empty; a few
      // requests in each burst flip the operation as noise.
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;
      for (int k = 2; k < 6; k++) key_pool[k] = CAR_ID_BITS'($urandom);
      burst = 0;
      while (queued_reqs.size() < RANDOM_REQS + 21) begin
         burst_len = (burst % 2 == 0) ? $urandom_range(1, 12) : $urandom_range(1, 10);
         for (int n = 0; n < burst_len; n++) begin
            op = (burst % 2 == 0) ? FUNC_PUSH : FUNC_REMOVE;
            if ($urandom_range(0, 9) == 0) op = (op == FUNC_PUSH) ? FUNC_REMOVE : FUNC_PUSH;
            if ($urandom_range(0, 99) < 75) key = key_pool[$urandom_range(0, 5)];
            else key = CAR_ID_BITS'($urandom);
            queued_reqs.push_back(make_req(op, key));
         end
         burst++;
      end
      total_reqs = queued_reqs.size();
   end

   // Reset, then wait for all requests to go through and all responses to
   // come back, then drain for the length of the slowest request.
   initial begin
      reset = 1'b1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (accepted_count < total_reqs || owed_rsps.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (owed_rsps.size() != 0) log_mismatch("responses still owed at the end");
      $display("Sent %0d requests: %0d keys stored, %0d pushes refused as full,",
               accepted_count, stored_count, refused_count);
      $display("%0d keys removed by search and %0d searches that found nothing.",
               removed_count, missed_count);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d responses owed.",
                  cycle_count, owed_rsps.size());
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Request driver. Runs on the falling edge so that the beat is stable
   // at the next rising edge. A new request is taken from the queue once
   // the previous beat has been accepted, or when nothing is being offered.
   always @(negedge clock) begin
      stack_req_type req;
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else if (!req_chan.valid || req_taken) begin
         if (queued_reqs.size() == 0 || (!steady_phase && $urandom_range(0, 99) < 17)) begin
            req_chan.valid <= 1'b0;
         end else begin
            req             = queued_reqs.pop_front();
            req_chan.valid  <= 1'b1;
            req_chan.func   <= req.op;
            req_chan.car_id <= req.car_id;
         end
      end
   end

   // Long receiver stall. Once a few hundred requests are in, the response
   // side holds off for a stretch while the driver keeps offering beats,
   // so the output register fills and the stack must stall its input.
   always @(negedge clock) begin
      if (!reset && !hold_done && accepted_count >= 350) begin
         hold_left <= 80;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Response ready, with random idling outside the steady window.
   always @(negedge clock) begin
      if (reset || hold_left > 0) begin
         rsp_chan.ready <= 1'b0;
      end else if (steady_phase) begin
         rsp_chan.ready <= 1'b1;
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 99) >= 17);
      end
   end

   // Monitor. On each rising edge it first checks an accepted response
   // beat against the oldest owed response, then runs an accepted request
   // beat through the local stack and records the response it must cause.
   always @(posedge clock) begin
      stack_req_type req;
      stack_rsp_type want;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         req_taken <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (owed_rsps.size() == 0) begin
               log_mismatch("response beat with no request behind it");
            end else begin
               want = owed_rsps.pop_front();
               if (rsp_chan.status !== want.status)
                  log_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_chan.status, want.status));
               if (rsp_chan.occupancy !== want.occupancy)
                  log_mismatch($sformatf("occupancy %0d, expected %0d",
                                         rsp_chan.occupancy, want.occupancy));
               if (rsp_chan.removed_position !== want.removed_position)
                  log_mismatch($sformatf("removed_position %0d, expected %0d",
                                         rsp_chan.removed_position,
                                         want.removed_position));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            req.op     = func_type'(req_chan.func);
            req.car_id = req_chan.car_id;
            apply_stack_req(req, want);
            owed_rsps.push_back(want);
            accepted_count <= accepted_count + 1;
            case (want.status)
               STATUS_FULL: begin
                  refused_count++;
               end
               STATUS_NOT_FOUND: begin
                  missed_count++;
               end
               default: begin
                  if (req.op == FUNC_PUSH) stored_count++;
                  else removed_count++;
               end
            endcase
         end
      end
   end

endmodule

/* filelist.f */
hw/rtl/swkr_pkg.sv
hw/rtl/swkr_if.sv
hw/rtl/swkr_mem.sv
hw/rtl/swkr_ctrl.sv
hw/rtl/stack_with_keyed_removal.sv
hw/rtl/swkr_checker.sv
bench/tb.sv
